/* sv/psbc_pkg.sv */
package psbc_pkg;

   // width of the tally field on the result channel
   localparam int TALLY_W = 11;

   // request function codes
   localparam logic FUNC_ADD   = 1'b0;
   localparam logic FUNC_QUERY = 1'b1;

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_SCAN  = 3'b010,
      ST_FINAL = 3'b100
   } state_type;

endpackage

/* sv/psbc_cell.sv */
module psbc_cell #(
   parameter int W = 64
) (
   input  logic         clock,
   input  logic         shift,
   input  logic [W-1:0] d_in,
   output logic [W-1:0] q
);

   logic [W-1:0] data_ff;

   // one point per cell, moves to the next cell on every shift
   always_ff @(posedge clock) begin
      if (shift) begin
         data_ff <= d_in;
      end
   end

   assign q = data_ff;

endmodule

/* sv/psbc_match.sv */
module psbc_match #(
   parameter int W = 32
) (
   input  logic [W-1:0] px,
   input  logic [W-1:0] py,
   input  logic [W-1:0] x_lo,
   input  logic [W-1:0] x_hi,
   input  logic [W-1:0] y_lo,
   input  logic [W-1:0] y_hi,
   output logic         hit
);

   // keys are offset binary, so plain unsigned compares order them
   logic in_x;
   logic in_y;

   assign in_x = (px >= x_lo) && (px <= x_hi);
   assign in_y = (py >= y_lo) && (py <= y_hi);
   assign hit  = in_x && in_y;

endmodule

/* sv/point_store_box_count_core.sv */
// point_store_box_count_core
//
// stores up to CAPACITY two-dimensional points and counts points inside a box
// request side: a beat is taken at a rising edge with start high and busy low
//   req_func selects add (point fields used) or query (box fields used)
//   coordinates are signed; the low COORD_BITS bits of each field are used
// response side: one beat per request, rsp_valid high for exactly one cycle;
//   the receiver cannot stall, so a response is never held back
// add: appends the point at the head of the cell ring; rsp_valid comes in the
//   cycle after the request beat and busy stays low, so adds go back to back;
//   a full store refuses the add and answers with rsp_refused set
// query: the cell ring rotates one full turn, one point past the compare
//   unit per cycle, then the final state sends the response beat; busy is
//   high through the scan and final states
// reset: clears the point count and the sequencer; point cells keep
//   whatever they held, but only cells holding written points are counted
module point_store_box_count_core
   import psbc_pkg::*;
#(
   parameter int CAPACITY   = 1024,
   parameter int COORD_BITS = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic                req_func,
   input  logic signed [31:0]  req_point_x,
   input  logic signed [31:0]  req_point_y,
   input  logic signed [31:0]  req_box_x_low,
   input  logic signed [31:0]  req_box_x_high,
   input  logic signed [31:0]  req_box_y_low,
   input  logic signed [31:0]  req_box_y_high,
   output logic                rsp_valid,
   output logic [TALLY_W-1:0]  rsp_tally,
   output logic                rsp_refused
);

   localparam int CW = $clog2(CAPACITY + 1);  // point count width
   localparam int SW = $clog2(CAPACITY);      // scan step width
   localparam int W  = COORD_BITS;
   localparam int PW = 2 * COORD_BITS;        // one cell: x key then y key

   // ---------------------------------------------------------------------
   // coordinate keys: low W bits with the sign bit flipped (offset binary)
   // ---------------------------------------------------------------------
   logic [31:0]  raw  [6];
   logic [W-1:0] wide [6];
   logic [W-1:0] key  [6];

   assign raw[0] = req_point_x;
   assign raw[1] = req_point_y;
   assign raw[2] = req_box_x_low;
   assign raw[3] = req_box_x_high;
   assign raw[4] = req_box_y_low;
   assign raw[5] = req_box_y_high;

   for (genvar k = 0; k < 6; k++) begin : g_key
      assign wide[k] = W'(raw[k]);
      assign key[k]  = {~wide[k][W-1], wide[k][W-2:0]};
   end

   // ---------------------------------------------------------------------
   // registers
   // ---------------------------------------------------------------------
   state_type    state_ff, state_in;
   logic [CW-1:0] fill_ff, fill_in;      // points stored
   logic [CW-1:0] skip_ff, skip_in;      // scan steps that see unwritten cells
   logic [CW-1:0] count_ff, count_in;    // hits so far
   logic [SW-1:0] step_ff, step_in;
   logic          hit_ff, hit_in;
   logic [W-1:0]  x_lo_ff, x_lo_in;
   logic [W-1:0]  x_hi_ff, x_hi_in;
   logic [W-1:0]  y_lo_ff, y_lo_in;
   logic [W-1:0]  y_hi_ff, y_hi_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          rsp_refused_ff, rsp_refused_in;
   logic [TALLY_W-1:0] rsp_tally_ff, rsp_tally_in;

   // ---------------------------------------------------------------------
   // cell ring: cell 0 is the newest point, the last cell feeds the
   // compare unit and wraps back to cell 0 during a query
   // ---------------------------------------------------------------------
   logic [PW-1:0] cell_q [CAPACITY];
   logic [PW-1:0] ring_in;
   logic [PW-1:0] tail;
   logic          shift_en;
   logic          match;

   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      if (g == 0) begin : g_head
         psbc_cell #(.W(PW)) u_cell (
            .clock (clock),
            .shift (shift_en),
            .d_in  (ring_in),
            .q     (cell_q[g])
         );
      end else begin : g_body
         psbc_cell #(.W(PW)) u_cell (
            .clock (clock),
            .shift (shift_en),
            .d_in  (cell_q[g-1]),
            .q     (cell_q[g])
         );
      end
   end

   assign tail = cell_q[CAPACITY-1];

   psbc_match #(.W(W)) u_match (
      .px   (tail[PW-1:W]),
      .py   (tail[W-1:0]),
      .x_lo (x_lo_ff),
      .x_hi (x_hi_ff),
      .y_lo (y_lo_ff),
      .y_hi (y_hi_ff),
      .hit  (match)
   );

   // ---------------------------------------------------------------------
   // sequencer
   // ---------------------------------------------------------------------
   logic               full;
   logic [CW-1:0]      tally_src;
   logic [CW+TALLY_W-1:0] tally_wide;

   assign full       = (fill_ff == CW'(CAPACITY));
   assign busy       = (state_ff != ST_IDLE);

   always_comb begin
      state_in       = state_ff;
      fill_in        = fill_ff;
      skip_in        = skip_ff;
      count_in       = count_ff;
      step_in        = step_ff;
      hit_in         = 1'b0;
      x_lo_in        = x_lo_ff;
      x_hi_in        = x_hi_ff;
      y_lo_in        = y_lo_ff;
      y_hi_in        = y_hi_ff;
      rsp_valid_in   = 1'b0;
      rsp_refused_in = rsp_refused_ff;
      tally_src      = fill_ff;
      shift_en       = 1'b0;
      ring_in        = tail;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (req_func == FUNC_ADD) begin
                  rsp_valid_in = 1'b1;
                  if (full) begin
                     // store full: nothing moves, answer the old count
                     rsp_refused_in = 1'b1;
                     tally_src      = fill_ff;
                  end else begin
                     shift_en       = 1'b1;
                     ring_in        = {key[0], key[1]};
                     fill_in        = fill_ff + CW'(1);
                     rsp_refused_in = 1'b0;
                     tally_src      = fill_in;
                  end
               end else begin
                  x_lo_in  = key[2];
                  x_hi_in  = key[3];
                  y_lo_in  = key[4];
                  y_hi_in  = key[5];
                  step_in  = '0;
                  count_in = '0;
                  skip_in  = CW'(CAPACITY) - fill_ff;
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            // tail at step j holds cell CAPACITY-1-j; it is a written
            // point when j reaches CAPACITY minus the fill count
            shift_en = 1'b1;
            hit_in   = match && (CW'(step_ff) >= skip_ff);
            count_in = count_ff + CW'(hit_ff);
            step_in  = step_ff + SW'(1);
            if (step_ff == SW'(CAPACITY - 1)) begin
               state_in = ST_FINAL;
            end
         end
         ST_FINAL: begin
            rsp_valid_in   = 1'b1;
            rsp_refused_in = 1'b0;
            tally_src      = count_ff + CW'(hit_ff);
            state_in       = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      tally_wide   = {{TALLY_W{1'b0}}, tally_src};
      rsp_tally_in = rsp_valid_in ? tally_wide[TALLY_W-1:0] : rsp_tally_ff;
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         hit_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         hit_ff       <= hit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload and scan bookkeeping
   always_ff @(posedge clock) begin
      skip_ff        <= skip_in;
      count_ff       <= count_in;
      step_ff        <= step_in;
      x_lo_ff        <= x_lo_in;
      x_hi_ff        <= x_hi_in;
      y_lo_ff        <= y_lo_in;
      y_hi_ff        <= y_hi_in;
      rsp_refused_ff <= rsp_refused_in;
      rsp_tally_ff   <= rsp_tally_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_tally   = rsp_tally_ff;
   assign rsp_refused = rsp_refused_ff;

   // ---------------------------------------------------------------------
   // assertions
   // ---------------------------------------------------------------------
   a_fill_bound : assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CW'(CAPACITY))
      else $error("point count above capacity");

   a_refuse_full : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_refused) |-> (fill_ff == CW'(CAPACITY)))
      else $error("add refused with room in the store");

   a_hits_bound : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINAL) |-> ((count_ff + CW'(hit_ff)) <= fill_ff))
      else $error("query counted more points than stored");

   a_query_busy : assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_func == FUNC_QUERY) |=> (busy && !rsp_valid))
      else $error("query beat did not start a scan");

endmodule

/* tb/tb.sv */
`timescale 1ns / 100ps

module tb
   import psbc_pkg::*;
();

   localparam int CAPACITY     = 1024;
   // how long a query takes from its request beat to its response beat
   localparam int SCAN_LATENCY = CAPACITY + 2;
   // quiet cycles allowed: one full scan plus the longest sender gap, more than twice over
   localparam int STALL_LIMIT  = 6000;
   localparam int REPORT_LIMIT = 10;
   localparam int NO_FIXED     = -1;
   // adds issued before the back-to-back run stops
   localparam int ADD_TARGET   = 430;

   localparam logic signed [31:0] C_MIN = 32'sh8000_0000;
   localparam logic signed [31:0] C_MAX = 32'sh7fff_ffff;
   localparam logic signed [31:0] ONE   = 32'sh0001_0000;  // 1.0 in q16.16

   // one request beat, with an optional hand-typed answer for the directed rows
   typedef struct {
      logic               func;
      logic signed [31:0] px, py, xl, xh, yl, yh;
      bit                 fixed;
      logic [TALLY_W-1:0] fixed_tally;
   } beat_type;

   typedef struct packed {
      logic [TALLY_W-1:0] tally;
      logic               refused;
   } answer_type;

   logic                clock;
   logic                reset;
   logic                start;
   logic                busy;
   logic                req_func;
   logic signed [31:0]  req_point_x;
   logic signed [31:0]  req_point_y;
   logic signed [31:0]  req_box_x_low;
   logic signed [31:0]  req_box_x_high;
   logic signed [31:0]  req_box_y_low;
   logic signed [31:0]  req_box_y_high;
   logic                rsp_valid;
   logic [TALLY_W-1:0]  rsp_tally;
   logic                rsp_refused;

   point_store_box_count_core #(
      .CAPACITY   (CAPACITY),
      .COORD_BITS (32)
   ) u_dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_func       (req_func),
      .req_point_x    (req_point_x),
      .req_point_y    (req_point_y),
      .req_box_x_low  (req_box_x_low),
      .req_box_x_high (req_box_x_high),
      .req_box_y_low  (req_box_y_low),
      .req_box_y_high (req_box_y_high),
      .rsp_valid      (rsp_valid),
      .rsp_tally      (rsp_tally),
      .rsp_refused    (rsp_refused)
   );

   initial clock = 1'b0;
   always #1 clock = ~clock;

   // shadow copy of the point store
   logic signed [31:0] shadow_x [CAPACITY];
   logic signed [31:0] shadow_y [CAPACITY];
   int                 shadow_count;

   answer_type answer_q[$];      // answers owed by the block, oldest first
   beat_type   directed_rows[$];
   int      faults;
   int      quiet_cycles;
   int      adds_issued;
   bit      steady;           // no sender gaps while set

   // answer for the beat currently offered, when it is typed into the table
   bit                 cur_fixed;
   logic [TALLY_W-1:0] cur_fixed_tally;

   // applies one accepted beat to the shadow store and returns its answer
   function automatic answer_type tally_beat(input beat_type b);
      answer_type a;
      int      hits;
      a.refused = 1'b0;
      if (b.func == FUNC_ADD) begin
         if (shadow_count >= CAPACITY) begin
            // store full: nothing written, count unchanged
            a.refused = 1'b1;
         end else begin
            shadow_x[shadow_count] = b.px;
            shadow_y[shadow_count] = b.py;
            shadow_count++;
         end
         a.tally = TALLY_W'(shadow_count);
      end else begin
         // inclusive box, signed compares; an inverted box simply matches nothing
         hits = 0;
         for (int i = 0; i < shadow_count; i++) begin
            if (shadow_x[i] >= b.xl && shadow_x[i] <= b.xh &&
                shadow_y[i] >= b.yl && shadow_y[i] <= b.yh)
               hits++;
         end
         a.tally = TALLY_W'(hits);
      end
      return a;
   endfunction

   task automatic log_fault(input string msg);
      faults++;
      if (faults <= REPORT_LIMIT)
         $display("%0t: %s", $time, msg);
   endtask

   // response check and request capture, both on the rising edge
   always @(posedge clock) begin : monitor
      answer_type want;
      answer_type got;
      beat_type   taken;
      if (!reset) begin
         // response beats first: an answer never shares an edge with its own request
         if (rsp_valid) begin
            got.tally   = rsp_tally;
            got.refused = rsp_refused;
            if (answer_q.size() == 0) begin
               log_fault($sformatf("response beat with nothing owed: tally %0d refused %0b",
                                   got.tally, got.refused));
            end else begin
               want = answer_q.pop_front();
               if (got.tally !== want.tally || got.refused !== want.refused)
                  log_fault($sformatf("expected tally %0d refused %0b, got tally %0d refused %0b",
                                      want.tally, want.refused, got.tally, got.refused));
            end
         end
         // request beat taken at this edge
         if (start && !busy) begin
            taken.func  = req_func;
            taken.px    = req_point_x;
            taken.py    = req_point_y;
            taken.xl    = req_box_x_low;
            taken.xh    = req_box_x_high;
            taken.yl    = req_box_y_low;
            taken.yh    = req_box_y_high;
            taken.fixed = 1'b0;
            want = tally_beat(taken);
            // typed-in answers replace the computed one
            if (cur_fixed) begin
               want.tally   = cur_fixed_tally;
               want.refused = 1'b0;
            end
            answer_q.push_back(want);
         end
      end
   end

   // ends the run when nothing moves on either channel for too long
   always @(posedge clock) begin : watchdog
      if (reset || (start && !busy) || rsp_valid)
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // q16.16 coordinate: most often a small integer grid so boxes catch points,
   // some extremes, the rest fully random bits
   function automatic logic signed [31:0] rand_coord();
      logic signed [31:0] v;
      case ($urandom_range(0, 19))
         0, 1, 2: begin
            case ($urandom_range(0, 6))
               0: v = C_MIN;
               1: v = C_MIN + 1;
               2: v = -1;
               3: v = 0;
               4: v = 1;
               5: v = C_MAX - 1;
               default: v = C_MAX;
            endcase
         end
         3, 4, 5, 6, 7, 8, 9, 10, 11: begin
            v = $urandom_range(0, 16);
            v = (v - 8) * ONE;
         end
         default: v = $urandom;
      endcase
      return v;
   endfunction

   // one box side: mostly ordered, sometimes inverted, sometimes the whole axis
   task automatic rand_span(output logic signed [31:0] lo, output logic signed [31:0] hi);
      logic signed [31:0] a;
      logic signed [31:0] b;
      a = rand_coord();
      b = rand_coord();
      if ($urandom_range(0, 9) == 0) begin
         a = C_MIN;
         b = C_MAX;
      end
      if ($urandom_range(0, 4) != 0 && a > b) begin
         lo = b;
         hi = a;
      end else begin
         lo = a;
         hi = b;
      end
   endtask

   // random beat; the fields the function ignores still carry random noise
   task automatic rand_beat(input logic func, output beat_type b);
      b.func  = func;
      b.px    = rand_coord();
      b.py    = rand_coord();
      rand_span(b.xl, b.xh);
      rand_span(b.yl, b.yh);
      b.fixed = 1'b0;
      b.fixed_tally = '0;
   endtask

   task automatic push_row(input logic func,
                           input logic signed [31:0] px, input logic signed [31:0] py,
                           input logic signed [31:0] xl, input logic signed [31:0] xh,
                           input logic signed [31:0] yl, input logic signed [31:0] yh,
                           input int fixed_tally);
      beat_type b;
      b.func  = func;
      b.px    = px;
      b.py    = py;
      b.xl    = xl;
      b.xh    = xh;
      b.yl    = yl;
      b.yh    = yh;
      b.fixed = (fixed_tally != NO_FIXED);
      b.fixed_tally = TALLY_W'(fixed_tally);
      directed_rows.push_back(b);
   endtask

   // offers one beat from the falling edge and holds it until the block takes it
   task automatic send_beat(input beat_type b);
      int gap;
      @(negedge clock);
      if (!steady && $urandom_range(0, 99) < 20) begin
         // mostly short gaps, now and then a longer one, up to long enough to span a whole scan
         gap = ($urandom_range(0, 29) == 0) ? $urandom_range(4, 1200) : $urandom_range(1, 3);
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_func        <= b.func;
      req_point_x     <= b.px;
      req_point_y     <= b.py;
      req_box_x_low   <= b.xl;
      req_box_x_high  <= b.xh;
      req_box_y_low   <= b.yl;
      req_box_y_high  <= b.yh;
      cur_fixed       = b.fixed;
      cur_fixed_tally = b.fixed_tally;
      start <= 1'b1;
      do @(posedge clock); while (busy);
      if (b.func == FUNC_ADD)
         adds_issued++;
   endtask

   initial begin
      beat_type b;
      reset           = 1'b1;
      start           = 1'b0;
      req_func        = FUNC_ADD;
      req_point_x     = '0;
      req_point_y     = '0;
      req_box_x_low   = '0;
      req_box_x_high  = '0;
      req_box_y_low   = '0;
      req_box_y_high  = '0;
      cur_fixed       = 1'b0;
      cur_fixed_tally = '0;
      steady          = 1'b0;
      faults          = 0;
      quiet_cycles    = 0;
      adds_issued     = 0;
      shadow_count    = 0;

      // directed rows: empty store, corner points, edges of the box, inverted boxes,
      // and noise on the fields each function ignores
      push_row(FUNC_QUERY, 0, 0, C_MIN, C_MAX, C_MIN, C_MAX, 0);
      push_row(FUNC_ADD, 0, 0, 0, 0, 0, 0, 1);
      push_row(FUNC_ADD, C_MAX, C_MAX, 0, 0, 0, 0, 2);
      push_row(FUNC_ADD, C_MIN, C_MIN, 0, 0, 0, 0, 3);
      push_row(FUNC_ADD, C_MIN, C_MAX, 0, 0, 0, 0, 4);
      push_row(FUNC_ADD, C_MAX, C_MIN, 0, 0, 0, 0, 5);
      push_row(FUNC_ADD, -1, ONE, 0, 0, 0, 0, 6);
      push_row(FUNC_QUERY, 0, 0, C_MIN, C_MAX, C_MIN, C_MAX, 6);
      push_row(FUNC_QUERY, 0, 0, ONE, 0, C_MIN, C_MAX, 0);           // x bounds inverted
      push_row(FUNC_QUERY, 0, 0, C_MIN, C_MAX, 1, -1, 0);            // y bounds inverted
      push_row(FUNC_QUERY, 0, 0, 0, 0, 0, 0, 1);                     // box shrunk to one point
      push_row(FUNC_QUERY, 0, 0, C_MAX, C_MAX, C_MIN, C_MAX, 2);
      push_row(FUNC_QUERY, 0, 0, C_MIN, -1, C_MIN, C_MAX, NO_FIXED);
      push_row(FUNC_QUERY, 0, 0, 0, C_MAX, 0, C_MAX, NO_FIXED);
      push_row(FUNC_ADD, ONE, -ONE, C_MAX, C_MIN, 32'sh5a5a_a5a5, 32'sh25a5_5a5a, 7);
      push_row(FUNC_QUERY, C_MIN, C_MAX, -1, ONE, -ONE, 0, NO_FIXED);
      push_row(FUNC_QUERY, C_MAX, C_MIN, C_MIN + 1, C_MAX - 1, C_MIN + 1, C_MAX - 1,
               NO_FIXED);
      push_row(FUNC_QUERY, 0, 0, -ONE, ONE, -ONE, ONE, NO_FIXED);
      push_row(FUNC_ADD, -1, -1, C_MIN, C_MAX, C_MIN, C_MAX, 8);
      push_row(FUNC_QUERY, -1, -1, -1, -1, -1, -1, NO_FIXED);

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         send_beat(directed_rows[i]);

      // mixed adds and queries on a partly filled store
      repeat (200) begin
         rand_beat(($urandom_range(0, 99) < 55) ? FUNC_ADD : FUNC_QUERY, b);
         send_beat(b);
      end

      // long run of back-to-back adds, a query now and then
      steady = 1'b1;
      while (adds_issued < ADD_TARGET) begin
         rand_beat(($urandom_range(0, 99) < 3) ? FUNC_QUERY : FUNC_ADD, b);
         send_beat(b);
      end
      steady = 1'b0;

      // busier store: adds between queries over every point
      repeat (40) begin
         rand_beat(($urandom_range(0, 1) == 0) ? FUNC_ADD : FUNC_QUERY, b);
         send_beat(b);
      end

      @(negedge clock);
      start <= 1'b0;
      cur_fixed = 1'b0;

      // drain, then give a stray late response time to show up
      while (answer_q.size() != 0)
         @(posedge clock);
      repeat (SCAN_LATENCY + 8) @(posedge clock);

      if (faults == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

/* sim.f */
sv/psbc_pkg.sv
sv/psbc_cell.sv
sv/psbc_match.sv
sv/point_store_box_count_core.sv
tb/tb.sv
